// ----- hw/rtl/olad_pkg.sv -----
// Shared types and codes for the ordered list block.
// No dependencies; imported by olad_alloc and ordered_list_append_delete.
`default_nettype none

package olad_pkg;

  // Input action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_HEAD     = 3'd3,
    ST_ONLY     = 3'd4,
    ST_TAIL     = 3'd5,
    ST_MIDDLE   = 3'd6,
    ST_NOTFOUND = 3'd7
  } status_t;

  // Free list commands from the sequencer
  typedef struct packed {
    logic pop;   // take free_head for an append
    logic push;  // return an unlinked entry to the front
  } alloc_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/olad_alloc.sv -----
// Free entry allocator: recycled stack head plus a fresh-entry watermark.
// Depends on olad_pkg (alloc_cmd_t).
`default_nettype none

module olad_alloc #(
  parameter int CAPACITY = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire olad_pkg::alloc_cmd_t           cmd,
  input  wire logic [$clog2(CAPACITY+1)-1:0]  pop_link,   // next link of free_head
  input  wire logic [$clog2(CAPACITY+1)-1:0]  push_idx,
  output logic      [$clog2(CAPACITY+1)-1:0]  free_head,
  output logic                                is_fresh,   // free_head never used yet
  output logic                                full
);
  import olad_pkg::*;

  localparam int IW = $clog2(CAPACITY+1);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] fresh_r, fresh_nxt;

  // Entries at or above the watermark still form the reset chain in order,
  // so their links need no storage.
  assign is_fresh  = (free_head_r == fresh_r);
  assign full      = (free_head_r == NIL);
  assign free_head = free_head_r;

  always_comb begin
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;
    if (cmd.pop) begin
      if (is_fresh) begin
        fresh_nxt     = fresh_r + IW'(1);
        free_head_nxt = fresh_r + IW'(1);
      end else begin
        free_head_nxt = pop_link;
      end
    end else if (cmd.push) begin
      free_head_nxt = push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      fresh_r     <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_append_delete.sv -----
// Ordered list with append at tail and delete of first equal value.
// Steps: full/empty and a fresh-entry append are answered from S_START; a
// recycled-entry append first reads the entry's link in S_POPRD; a delete walks
// from the head in S_WALK, plus S_LINK for a middle entry. One word at a time.
// The walk does one read of the value/link memories per cycle while it advances.
// Reset: synchronous, active low; empties the list, no memory clearing pass.
`default_nettype none

module ordered_list_append_delete #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_action,
  input  wire logic signed [31:0] in_item_value,
  // result words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic        [2:0]       out_status,
  output logic        [4:0]       out_entry_count
);
  import olad_pkg::*;

  localparam int IW = $clog2(CAPACITY+1);        // link width, holds null
  localparam int AW = $clog2(CAPACITY);          // memory address width
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an input word
    S_START,  // decode the word against head/tail/free state
    S_POPRD,  // link of a recycled free entry is being read
    S_WALK,   // one list entry per cycle from the head; may wait on the output at the end
    S_LINK    // middle removal: splice predecessor to successor
  } state_t;

  state_t state_r, state_nxt;

  // Captured word
  logic                   act_r, act_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;

  // List pointers
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] cur_r, cur_nxt;     // entry under compare
  logic [IW-1:0] prev_r, prev_nxt;   // entry walked just before it

  // Result register
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  logic [4:0]    out_count_r, out_count_nxt;

  // Value and forward link memories, one shared read address
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [IW-1:0]          nxt_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_rd_r;
  logic [IW-1:0]          nxt_rd_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   val_we;
  logic [AW-1:0]          val_waddr;
  logic                   nxt_we;
  logic [AW-1:0]          nxt_waddr;
  logic [IW-1:0]          nxt_wdata;

  // Free list
  alloc_cmd_t    cmd;
  logic [IW-1:0] free_head;
  logic          is_fresh;
  logic          full;

  // Step control
  logic          out_free;
  logic          app_go;   // link free_head in at the tail
  logic          rel_go;   // push cur onto the free list
  logic          fin;
  status_t       fin_status;

  olad_alloc #(
    .CAPACITY (CAPACITY)
  ) u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .pop_link  (nxt_rd_r),
    .push_idx  (cur_r),
    .free_head (free_head),
    .is_fresh  (is_fresh),
    .full      (full)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  // Reads and writes never hit the same cycle, so no forwarding is needed:
  // reads occur only in S_START / S_WALK steps, writes only on append, release or splice.
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    val_we         = 1'b0;
    val_waddr      = '0;
    nxt_we         = 1'b0;
    nxt_waddr      = '0;
    nxt_wdata      = '0;
    cmd            = '0;
    app_go         = 1'b0;
    rel_go         = 1'b0;
    fin            = 1'b0;
    fin_status     = ST_APPENDED;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = in_action;
          val_nxt   = VALUE_WIDTH'(in_item_value);  // sign-extend or truncate
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (act_r == ACT_APPEND) begin
          if (full) begin
            if (out_free) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end
          end else if (is_fresh) begin
            app_go = out_free;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = free_head[AW-1:0];
            state_nxt = S_POPRD;
          end
        end else begin
          if (head_r == NIL) begin
            if (out_free) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end
          end else begin
            rd_en     = 1'b1;
            rd_addr   = head_r[AW-1:0];
            cur_nxt   = head_r;
            prev_nxt  = NIL;
            state_nxt = S_WALK;
          end
        end
      end
      S_POPRD: begin
        app_go = out_free;
      end
      S_WALK: begin
        // tail is detected by index, so its stored link is never followed
        if (val_rd_r == val_r) begin
          if (cur_r == head_r) begin
            if (out_free) begin
              rel_go = 1'b1;
              fin    = 1'b1;
              if (cur_r == tail_r) begin
                head_nxt   = NIL;
                tail_nxt   = NIL;
                fin_status = ST_ONLY;
              end else begin
                head_nxt   = nxt_rd_r;
                fin_status = ST_HEAD;
              end
            end
          end else if (cur_r == tail_r) begin
            if (out_free) begin
              rel_go     = 1'b1;
              tail_nxt   = prev_r;
              fin        = 1'b1;
              fin_status = ST_TAIL;
            end
          end else begin
            rel_go    = 1'b1;
            state_nxt = S_LINK;
          end
        end else if (cur_r == tail_r) begin
          if (out_free) begin
            fin        = 1'b1;
            fin_status = ST_NOTFOUND;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = nxt_rd_r[AW-1:0];
          prev_nxt = cur_r;
          cur_nxt  = nxt_rd_r;
        end
      end
      S_LINK: begin
        // successor link still held in the read register
        if (out_free) begin
          nxt_we     = 1'b1;
          nxt_waddr  = prev_r[AW-1:0];
          nxt_wdata  = nxt_rd_r;
          fin        = 1'b1;
          fin_status = ST_MIDDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (app_go) begin
      val_we    = 1'b1;
      val_waddr = free_head[AW-1:0];
      if (tail_r != NIL) begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_r[AW-1:0];
        nxt_wdata = free_head;
      end else begin
        head_nxt = free_head;
      end
      tail_nxt   = free_head;
      cnt_nxt    = cnt_r + IW'(1);
      cmd.pop    = 1'b1;
      fin        = 1'b1;
      fin_status = ST_APPENDED;
    end

    if (rel_go) begin
      nxt_we    = 1'b1;
      nxt_waddr = cur_r[AW-1:0];
      nxt_wdata = free_head;
      cnt_nxt   = cnt_r - IW'(1);
      cmd.push  = 1'b1;
    end

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_count_nxt  = 5'(cnt_nxt);
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Memories: one write port each, shared registered read
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_r;
    end
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (rd_en) begin
      val_rd_r <= val_mem[rd_addr];
      nxt_rd_r <= nxt_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
